FILE: hw/rtl/d2rgb_pkg.sv
// Shared types and constants for the depth-to-RGB colour map.
// Holds zone codes, register indexes, fixed colours and the ramp stop table.
// No dependencies.
`timescale 1ns / 1ps

package d2rgb_pkg;

  // Configuration port
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE = 1'b0,
    REG_MAX_RANGE = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] MIN_RANGE_RESET = 16'd100;
  localparam logic [CFG_W-1:0] MAX_RANGE_RESET = 16'd10000;

  // Zone code on the result
  typedef enum logic [1:0] {
    ZONE_BLIND = 2'd0,
    ZONE_RANGE = 2'd1,
    ZONE_FAR   = 2'd2
  } zone_t;

  // Colour channels
  localparam int unsigned NUM_CH = 3;
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Flat colours for blind zone and far / no-hit
  localparam logic [7:0] BLIND_RED   = 8'd200;
  localparam logic [7:0] BLIND_GREEN = 8'd0;
  localparam logic [7:0] BLIND_BLUE  = 8'd200;
  localparam logic [7:0] FAR_RED     = 8'd20;
  localparam logic [7:0] FAR_GREEN   = 8'd20;
  localparam logic [7:0] FAR_BLUE    = 8'd30;

  // Five ramp stops: red, orange, yellow, green, blue
  function automatic logic [7:0] ramp_level(input logic [2:0] stop, input logic [1:0] ch);
    logic [23:0] rgb;
    case (stop)
      3'd0:    rgb = {8'd255, 8'd40,  8'd40};
      3'd1:    rgb = {8'd255, 8'd160, 8'd0};
      3'd2:    rgb = {8'd245, 8'd245, 8'd0};
      3'd3:    rgb = {8'd40,  8'd220, 8'd60};
      3'd4:    rgb = {8'd40,  8'd90,  8'd255};
      default: rgb = {8'd40,  8'd90,  8'd255};
    endcase
    case (ch)
      CH_RED:   return rgb[23:16];
      CH_GREEN: return rgb[15:8];
      CH_BLUE:  return rgb[7:0];
      default:  return rgb[7:0];
    endcase
  endfunction

endpackage

FILE: hw/rtl/depth_to_rgb_colormap_top.sv
// Top level of the depth-to-RGB colour map: range check, pipelined divider,
// per-channel blend and output register. Depends on d2rgb_pkg.
`timescale 1ns / 1ps

// Takes one depth sample per clock and returns one colour per sample, on
// out_valid, once the request has passed stage A, the divider, the blend stage
// and the output register. Most of that pipeline is the restoring divider
// that normalises the depth against the range window: it resolves one bit of
// the FRAC_BITS+2 bit ramp position per pipeline stage. There is no stall on
// either side: busy is low whenever reset is released and results cannot be
// held off, so take every out_valid cycle. Write min/max range only while no
// request is in flight.
module depth_to_rgb_colormap_top #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request
  input  logic                              start,
  output logic                              busy,
  input  logic [DEPTH_BITS-1:0]             in_depth_mm,
  // result
  output logic                              out_valid,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic [1:0]                        out_zone,
  // configuration
  input  logic                              cfg_we,
  input  logic [d2rgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [d2rgb_pkg::CFG_W-1:0]       cfg_data
);

  localparam int unsigned QW    = FRAC_BITS + 2;   // ramp position bits
  localparam int unsigned ACC_W = FRAC_BITS + 10;  // signed blend accumulator

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [d2rgb_pkg::CFG_W-1:0] min_range_r, max_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= d2rgb_pkg::MIN_RANGE_RESET;
      max_range_r <= d2rgb_pkg::MAX_RANGE_RESET;
    end else if (cfg_we) begin
      case (d2rgb_pkg::cfg_reg_t'(cfg_index))
        d2rgb_pkg::REG_MIN_RANGE: min_range_r <= cfg_data;
        d2rgb_pkg::REG_MAX_RANGE: max_range_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block requests only while in reset
  assign busy = ~rst_n;

  // ---------------------------------------------------------------------------
  // Stage A: classify the sample and form the divider's first remainder
  logic [DEPTH_BITS-1:0] lo_w, hi_w, rem0_nxt;
  d2rgb_pkg::zone_t      zone0_nxt;
  logic                  accept;

  assign lo_w   = DEPTH_BITS'(min_range_r);
  assign hi_w   = DEPTH_BITS'(max_range_r);
  assign accept = start & ~busy;

  always_comb begin
    if (in_depth_mm == '0) begin
      zone0_nxt = d2rgb_pkg::ZONE_BLIND;
    end else if (in_depth_mm >= hi_w || lo_w >= hi_w) begin
      zone0_nxt = d2rgb_pkg::ZONE_FAR;
    end else begin
      zone0_nxt = d2rgb_pkg::ZONE_RANGE;
    end
    rem0_nxt = (in_depth_mm > lo_w) ? (in_depth_mm - lo_w) : '0;
  end

  // Window width; the user keeps it constant while requests are in flight, the block does not enforce it
  logic [DEPTH_BITS-1:0] div_r;

  always_ff @(posedge clk) begin
    div_r <= hi_w - lo_w;
  end

  // Pipeline registers: index 0 is stage A, index k+1 follows divider step k
  logic                  vld_r  [QW+1];
  d2rgb_pkg::zone_t      zone_r [QW+1];
  logic [DEPTH_BITS-1:0] rem_r  [QW+1];
  logic [QW-1:0]         quo_r  [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    zone_r[0] <= zone0_nxt;
    rem_r[0]  <= rem0_nxt;
    quo_r[0]  <= '0;
  end

  // ---------------------------------------------------------------------------
  // Divider: one quotient bit per stage. In range, the remainder stays below the
  // window width, so the quotient is floor(rem0 * 2^QW / width) with no overflow.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DEPTH_BITS:0]   twice, diff;
    logic                  take;
    logic [DEPTH_BITS-1:0] rem_nxt;
    logic [QW-1:0]         quo_nxt;

    always_comb begin
      twice   = {rem_r[k], 1'b0};
      diff    = twice - {1'b0, div_r};
      take    = (twice >= {1'b0, div_r});
      rem_nxt = take ? diff[DEPTH_BITS-1:0] : twice[DEPTH_BITS-1:0];
      quo_nxt = {quo_r[k][QW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      zone_r[k+1] <= zone_r[k];
      rem_r[k+1]  <= rem_nxt;
      quo_r[k+1]  <= quo_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Blend stage: pick the segment and interpolate each channel
  logic [1:0]              seg;
  logic [2:0]              seg_next;
  logic [FRAC_BITS-1:0]    frac;
  logic signed [ACC_W-1:0] acc_nxt [d2rgb_pkg::NUM_CH];
  logic signed [ACC_W-1:0] acc_r   [d2rgb_pkg::NUM_CH];
  logic                    bl_vld_r;
  d2rgb_pkg::zone_t        bl_zone_r;

  assign seg      = quo_r[QW][QW-1:FRAC_BITS];
  assign seg_next = {1'b0, seg} + 3'd1;
  assign frac     = quo_r[QW][FRAC_BITS-1:0];

  always_comb begin
    logic [7:0]              c0, c1;
    logic signed [8:0]       step;
    logic signed [ACC_W-1:0] base, prod;
    for (int ch = 0; ch < d2rgb_pkg::NUM_CH; ch++) begin
      c0   = d2rgb_pkg::ramp_level({1'b0, seg}, 2'(ch));
      c1   = d2rgb_pkg::ramp_level(seg_next, 2'(ch));
      step = $signed({1'b0, c1}) - $signed({1'b0, c0});
      base = $signed(ACC_W'({c0, {FRAC_BITS{1'b0}}}));
      prod = $signed(ACC_W'({1'b0, frac})) * ACC_W'(step);
      acc_nxt[ch] = base + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_vld_r <= 1'b0;
    end else begin
      bl_vld_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    bl_zone_r <= zone_r[QW];
    for (int ch = 0; ch < d2rgb_pkg::NUM_CH; ch++) begin
      acc_r[ch] <= acc_nxt[ch];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: round down, override with the flat colours
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic       out_valid_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic [1:0] out_zone_r;

  always_comb begin
    case (bl_zone_r)
      d2rgb_pkg::ZONE_BLIND: begin
        red_nxt   = d2rgb_pkg::BLIND_RED;
        green_nxt = d2rgb_pkg::BLIND_GREEN;
        blue_nxt  = d2rgb_pkg::BLIND_BLUE;
      end
      d2rgb_pkg::ZONE_FAR: begin
        red_nxt   = d2rgb_pkg::FAR_RED;
        green_nxt = d2rgb_pkg::FAR_GREEN;
        blue_nxt  = d2rgb_pkg::FAR_BLUE;
      end
      default: begin
        red_nxt   = acc_r[d2rgb_pkg::CH_RED][FRAC_BITS+7:FRAC_BITS];
        green_nxt = acc_r[d2rgb_pkg::CH_GREEN][FRAC_BITS+7:FRAC_BITS];
        blue_nxt  = acc_r[d2rgb_pkg::CH_BLUE][FRAC_BITS+7:FRAC_BITS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= bl_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_red_r   <= red_nxt;
    out_green_r <= green_nxt;
    out_blue_r  <= blue_nxt;
    out_zone_r  <= bl_zone_r;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_zone  = out_zone_r;

endmodule

FILE: hw/rtl/d2rgb_checker.sv
// Port-level checks for the depth-to-RGB colour map, bound to the top level.
// Depends on d2rgb_pkg and depth_to_rgb_colormap_top.
`timescale 1ns / 1ps

module d2rgb_checker #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [DEPTH_BITS-1:0] in_depth_mm,
  input logic                  out_valid,
  input logic [7:0]            out_red,
  input logic [7:0]            out_green,
  input logic [7:0]            out_blue,
  input logic [1:0]            out_zone
);

  localparam int unsigned LATENCY = FRAC_BITS + 5;

  // Every request gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request produced no result at fixed latency");

  // No result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result without a matching request");

  // Zero depth lands in the blind zone
  a_zero_blind: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_depth_mm == '0) |-> ##LATENCY
      (out_zone == d2rgb_pkg::ZONE_BLIND && out_red == d2rgb_pkg::BLIND_RED &&
       out_green == d2rgb_pkg::BLIND_GREEN && out_blue == d2rgb_pkg::BLIND_BLUE))
    else $error("zero depth not mapped to blind colour");

  // Far zone carries the flat far colour
  a_far_colour: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zone == d2rgb_pkg::ZONE_FAR) |->
      (out_red == d2rgb_pkg::FAR_RED && out_green == d2rgb_pkg::FAR_GREEN &&
       out_blue == d2rgb_pkg::FAR_BLUE))
    else $error("far zone with wrong colour");

endmodule

bind depth_to_rgb_colormap_top d2rgb_checker #(
  .DEPTH_BITS(DEPTH_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_d2rgb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_depth_mm(in_depth_mm),
  .out_valid  (out_valid),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue),
  .out_zone   (out_zone)
);

FILE: tb/sv/tb_depth_to_rgb_colormap_top.sv
// Self-checking testbench for the depth-to-RGB colour map top level.
// Drives depth requests and range writes, predicts each colour and zone, compares
// them with the results. Depends on d2rgb_pkg and depth_to_rgb_colormap_top.
`timescale 1ns / 1ps

module tb_depth_to_rgb_colormap_top;

  localparam int DEPTH_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int FRAC_ONE   = 1 << FRAC_BITS;
  localparam int LATENCY    = FRAC_BITS + 5;
  localparam int SETTLE     = LATENCY + 4;
  localparam int LIMIT      = 200000;

  typedef enum {PEND_DEPTH, PEND_CFG, PEND_HOLD} pend_kind_t;

  typedef struct {
    pend_kind_t                      kind;
    logic [DEPTH_BITS-1:0]           depth;
    d2rgb_pkg::cfg_reg_t             reg_idx;
    logic [d2rgb_pkg::CFG_W-1:0]     value;
    int                              gap_pct;
  } pend_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    d2rgb_pkg::zone_t zone;
  } colour_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [DEPTH_BITS-1:0]             in_depth_mm = '0;
  logic                              out_valid;
  logic [7:0]                        out_red;
  logic [7:0]                        out_green;
  logic [7:0]                        out_blue;
  logic [1:0]                        out_zone;
  logic                              cfg_we = 1'b0;
  logic [d2rgb_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [d2rgb_pkg::CFG_W-1:0]       cfg_data = '0;

  pend_t   pending[$];
  colour_t colours_due[$];
  logic [d2rgb_pkg::CFG_W-1:0] range_lo = d2rgb_pkg::MIN_RANGE_RESET;
  logic [d2rgb_pkg::CFG_W-1:0] range_hi = d2rgb_pkg::MAX_RANGE_RESET;
  int      fill_gap = 0;
  int      err_count = 0;
  int      cycle_count = 0;
  int      quiet = 0;
  bit      taken_last = 1'b0;

  depth_to_rgb_colormap_top #(
    .DEPTH_BITS(DEPTH_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_depth_mm(in_depth_mm),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_zone   (out_zone),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Ramp stops, packed as {red, green, blue}
  function automatic logic [23:0] stop_rgb(input int stop);
    case (stop)
      0:       return {8'd255, 8'd40,  8'd40};
      1:       return {8'd255, 8'd160, 8'd0};
      2:       return {8'd245, 8'd245, 8'd0};
      3:       return {8'd40,  8'd220, 8'd60};
      default: return {8'd40,  8'd90,  8'd255};
    endcase
  endfunction

  function automatic logic [7:0] blend(input int c0, input int c1, input int frac);
    int acc;
    acc = c0 * FRAC_ONE + frac * (c1 - c0);
    if (acc < 0) acc = 0;
    return 8'(acc >> FRAC_BITS);
  endfunction

  // Colour and zone for one depth under the given range window
  function automatic colour_t map_depth(input logic [DEPTH_BITS-1:0] d,
                                        input logic [d2rgb_pkg::CFG_W-1:0] lo,
                                        input logic [d2rgb_pkg::CFG_W-1:0] hi);
    colour_t    c;
    longint     pos;
    int         seg;
    int         frac;
    logic [23:0] c0;
    logic [23:0] c1;
    pos = 0;
    if (d == 0) begin
      c = '{d2rgb_pkg::BLIND_RED, d2rgb_pkg::BLIND_GREEN, d2rgb_pkg::BLIND_BLUE,
            d2rgb_pkg::ZONE_BLIND};
    end else if (d >= hi || lo >= hi) begin
      c = '{d2rgb_pkg::FAR_RED, d2rgb_pkg::FAR_GREEN, d2rgb_pkg::FAR_BLUE,
            d2rgb_pkg::ZONE_FAR};
    end else begin
      if (d > lo)
        pos = ((longint'(d) - longint'(lo)) * 4 * FRAC_ONE) / (longint'(hi) - longint'(lo));
      seg = int'(pos >> FRAC_BITS);
      if (seg > 3) seg = 3;
      frac = int'(pos) - (seg << FRAC_BITS);
      if (frac >= FRAC_ONE) frac = FRAC_ONE - 1;
      c0 = stop_rgb(seg);
      c1 = stop_rgb(seg + 1);
      c.red   = blend(c0[23:16], c1[23:16], frac);
      c.green = blend(c0[15:8],  c1[15:8],  frac);
      c.blue  = blend(c0[7:0],   c1[7:0],   frac);
      c.zone  = d2rgb_pkg::ZONE_RANGE;
    end
    return c;
  endfunction

  task automatic add_depth(input int d);
    pend_t p;
    p = '{PEND_DEPTH, DEPTH_BITS'(d), d2rgb_pkg::REG_MIN_RANGE, '0, fill_gap};
    pending.push_back(p);
  endtask

  task automatic add_cfg(input d2rgb_pkg::cfg_reg_t idx, input int val);
    pend_t p;
    p = '{PEND_CFG, '0, idx, d2rgb_pkg::CFG_W'(val), fill_gap};
    pending.push_back(p);
  endtask

  task automatic add_hold();
    pend_t p;
    p = '{PEND_HOLD, '0, d2rgb_pkg::REG_MIN_RANGE, '0, fill_gap};
    pending.push_back(p);
  endtask

  task automatic add_setting(input int lo, input int hi);
    add_cfg(d2rgb_pkg::REG_MIN_RANGE, lo);
    add_cfg(d2rgb_pkg::REG_MAX_RANGE, hi);
  endtask

  // Half the depths inside the window, with blind, far, edge and raw values mixed in
  task automatic add_random(input int lo, input int hi, input int count);
    int d;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0:       d = 0;
        1, 2:    d = $urandom_range(0, 65535);
        3:       d = $urandom_range(hi, 65535);
        4:       d = (lo > 0 && $urandom_range(0, 1)) ? lo - 1 : lo;
        default: d = (lo < hi) ? $urandom_range(lo, hi - 1) : $urandom_range(0, 65535);
      endcase
      add_depth(d);
    end
  endtask

  // Driver: raise a request, hold it until taken, write ranges only once drained
  always @(negedge clk) begin : drive
    logic                              start_n;
    logic                              we_n;
    logic [DEPTH_BITS-1:0]             depth_n;
    logic [d2rgb_pkg::CFG_IDX_W-1:0]   idx_n;
    logic [d2rgb_pkg::CFG_W-1:0]       data_n;
    pend_t                             p;
    start_n = start;
    we_n    = 1'b0;
    depth_n = in_depth_mm;
    idx_n   = cfg_index;
    data_n  = cfg_data;
    if (rst_n && (!start || taken_last)) begin
      start_n = 1'b0;
      if (pending.size() != 0) begin
        p = pending[0];
        if (p.kind == PEND_DEPTH) begin
          if ($urandom_range(0, 99) >= p.gap_pct) begin
            void'(pending.pop_front());
            start_n = 1'b1;
            depth_n = p.depth;
          end
        end else if (colours_due.size() == 0 && quiet >= SETTLE) begin
          void'(pending.pop_front());
          if (p.kind == PEND_CFG) begin
            we_n   = 1'b1;
            idx_n  = p.reg_idx;
            data_n = p.value;
          end
        end
      end
    end
    start       <= start_n;
    cfg_we      <= we_n;
    in_depth_mm <= depth_n;
    cfg_index   <= idx_n;
    cfg_data    <= data_n;
  end

  // Monitor: check results, predict accepted requests, track range writes
  always @(posedge clk) begin : watch
    colour_t want;
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      taken_last = 1'b0;
      if (rst_n) begin
        quiet++;
        if (out_valid) begin
          quiet = 0;
          if (colours_due.size() == 0) begin
            $error("unexpected result: red %0d green %0d blue %0d zone %0d",
                   out_red, out_green, out_blue, out_zone);
            err_count++;
          end else begin
            want = colours_due.pop_front();
            if (out_red !== want.red) begin
              $error("red: expected %0d, got %0d", want.red, out_red);
              err_count++;
            end
            if (out_green !== want.green) begin
              $error("green: expected %0d, got %0d", want.green, out_green);
              err_count++;
            end
            if (out_blue !== want.blue) begin
              $error("blue: expected %0d, got %0d", want.blue, out_blue);
              err_count++;
            end
            if (out_zone !== want.zone) begin
              $error("zone: expected %0d, got %0d", want.zone, out_zone);
              err_count++;
            end
          end
        end
        if (start && !busy) begin
          colours_due.push_back(map_depth(in_depth_mm, range_lo, range_hi));
          taken_last = 1'b1;
          quiet = 0;
        end
        if (cfg_we) begin
          case (d2rgb_pkg::cfg_reg_t'(cfg_index))
            d2rgb_pkg::REG_MIN_RANGE: range_lo = cfg_data;
            d2rgb_pkg::REG_MAX_RANGE: range_hi = cfg_data;
            default: ;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int lo;
    int hi;

    // Reset window: blind, edges, segment boundaries, far, raw bit patterns
    fill_gap = 24;
    add_depth(0);
    add_depth(1);
    add_depth(99);
    add_depth(100);
    add_depth(101);
    add_depth(2574);
    add_depth(2575);
    add_depth(7525);
    add_depth(9999);
    add_depth(10000);
    add_depth(16'h5555);
    add_depth(16'haaaa);
    add_depth(16'hffff);
    add_random(100, 10000, 40);

    // Widest window
    add_setting(0, 65535);
    add_depth(65534);
    add_depth(65535);
    add_random(0, 65535, 40);

    // Narrowest window at the top of the range
    add_setting(65534, 65535);
    add_random(65534, 65535, 30);

    // Empty window: min equals max, zero still blind
    fill_gap = 65;
    add_setting(500, 500);
    add_depth(500);
    add_depth(0);
    add_random(500, 500, 30);

    add_setting(0, 1);
    add_random(0, 1, 15);
    add_hold();
    add_random(0, 1, 15);

    // Max of zero: everything non-zero is far
    add_setting(1234, 0);
    add_depth(1);
    add_depth(65535);
    add_random(1234, 0, 30);

    // Min above max
    fill_gap = 0;
    add_setting(60000, 1000);
    add_depth(999);
    add_depth(60001);
    add_random(60000, 1000, 30);

    for (int k = 0; k < 3; k++) begin
      lo = $urandom_range(0, 60000);
      hi = $urandom_range(lo + 1, 65535);
      add_setting(lo, hi);
      add_random(lo, hi, 40);
    end

    add_setting(1000, 2000);
    add_random(1000, 2000, 40);

    // Hold reset, then release it
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: all requests taken, all results in, then let the pipe settle
    while (pending.size() != 0 || start) @(posedge clk);
    while (colours_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
